### src/slli_pkg.sv
package slli_pkg;

    localparam int NODES_DEF    = 16;
    localparam int KEY_BITS_DEF = 16;

    // command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    // result kinds
    typedef enum logic [1:0] {
        KIND_INSERTED = 2'd0,
        KIND_OVERFLOW = 2'd1,
        KIND_ENTRY    = 2'd2,
        KIND_EMPTY    = 2'd3
    } kind_t;

    // per-cycle control common to all cells
    typedef struct packed {
        logic rot;
    } cell_ctl_t;

    // insert carry handed from one cell to the next
    typedef struct packed {
        logic valid;
        logic first;
    } carry_t;

    // cell status seen by the controller
    typedef struct packed {
        logic first_hit;
        logic landed;
    } cell_stat_t;

endpackage

### src/slli_cell.sv
module slli_cell #(
    parameter int KEY_BITS = slli_pkg::KEY_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  slli_pkg::cell_ctl_t     ctl,
    input  slli_pkg::carry_t        cin,
    input  logic [KEY_BITS-1:0]     cin_key,
    input  logic                    rin_vld,
    input  logic [KEY_BITS-1:0]     rin_key,
    output logic                    vld,
    output logic [KEY_BITS-1:0]     key,
    output slli_pkg::carry_t        cout,
    output logic [KEY_BITS-1:0]     cout_key,
    output slli_pkg::cell_stat_t    stat
);

    logic                vld_reg;
    logic                vld_next;
    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;
    slli_pkg::carry_t    car_reg;
    slli_pkg::carry_t    car_next;
    logic [KEY_BITS-1:0] car_key_reg;
    logic [KEY_BITS-1:0] car_key_next;
    logic                less;

    // incoming key goes in front of the held one when it is strictly smaller
    assign less = cin_key < key_reg;

    always_comb
    begin
        vld_next     = vld_reg;
        key_next     = key_reg;
        car_next     = '0;
        car_key_next = car_key_reg;
        if (ctl.rot)
        begin
            vld_next = rin_vld;
            key_next = rin_key;
        end
        else if (cin.valid)
        begin
            if (!vld_reg)
            begin
                vld_next = 1'b1;
                key_next = cin_key;
            end
            else
            begin
                car_next.valid = 1'b1;
                car_next.first = cin.first & ~less;
                if (less)
                begin
                    key_next     = cin_key;
                    car_key_next = key_reg;
                end
                else
                begin
                    car_key_next = cin_key;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            car_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
            car_reg <= car_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        car_key_reg <= car_key_next;
    end

    assign vld            = vld_reg;
    assign key            = key_reg;
    assign cout           = car_reg;
    assign cout_key       = car_key_reg;
    assign stat.first_hit = cin.valid & cin.first & (~vld_reg | less);
    assign stat.landed    = cin.valid & ~vld_reg;

endmodule

### src/sorted_linked_list_insert_unit.sv
// sorted key list kept in a row of NODES cells, cell i holding the i-th smallest key; an
// insert beat (cmd 0) answers one result: kind 0 with the key and its ascending rank (equal
// keys rank after earlier ones), or kind 1 with rank 0 when all NODES cells are in use, in
// which case nothing changes; a read-out beat (cmd 1) answers every stored key in ascending
// order as kind 2 with its rank, last set on the final one, or a single kind 3 beat when the
// list is empty; one item is worked at a time: an insert takes its key through the row one
// cell per cycle until it drops into the first empty cell; a read-out rotates the whole
// row NODES times through cell 0, one step per cycle that the output register can take a
// beat; overflow and empty read-out go straight to their single result; the next input
// beat is taken while the last result still waits in the output register
module sorted_linked_list_insert_unit #(
    parameter int NODES    = slli_pkg::NODES_DEF,
    parameter int KEY_BITS = slli_pkg::KEY_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [15:0] new_key,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [15:0] key_out,
    output logic [5:0]  position,
    output logic        last
);

    localparam int IW = $clog2(NODES);
    localparam int CW = $clog2(NODES + 1);

    // controller states, one-hot
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_INS  = 4'b0010,
        S_ROT  = 4'b0100,
        S_RES  = 4'b1000
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic [IW-1:0]          step_reg;
    logic [IW-1:0]          step_next;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;

    // token injected into cell 0
    slli_pkg::carry_t       inj_reg;
    slli_pkg::carry_t       inj_next;
    logic [KEY_BITS-1:0]    inj_key_reg;
    logic [KEY_BITS-1:0]    inj_key_next;

    // pending single result (insert, overflow, empty read-out)
    slli_pkg::kind_t        res_kind_reg;
    slli_pkg::kind_t        res_kind_next;
    logic [15:0]            res_key_reg;
    logic [15:0]            res_key_next;
    logic [5:0]             res_pos_reg;
    logic [5:0]             res_pos_next;

    // output register
    logic                   out_valid_reg;
    logic                   out_valid_next;
    slli_pkg::kind_t        kind_reg;
    slli_pkg::kind_t        kind_next;
    logic [15:0]            key_out_reg;
    logic [15:0]            key_out_next;
    logic [5:0]             position_reg;
    logic [5:0]             position_next;
    logic                   last_reg;
    logic                   last_next;

    // cell row
    slli_pkg::cell_ctl_t    ctl;
    slli_pkg::carry_t       car_arr [NODES+1];
    logic [KEY_BITS-1:0]    car_key_arr [NODES+1];
    logic                   vld_arr [NODES];
    logic [KEY_BITS-1:0]    key_arr [NODES];
    slli_pkg::cell_stat_t   stat_arr [NODES];
    logic [NODES-1:0]       hit_vec;
    logic [NODES-1:0]       land_vec;

    logic                   accept;
    logic                   out_free;
    logic                   any_hit;
    logic                   any_land;
    logic [KEY_BITS-1:0]    key_in;

    // key reduced to the stored width
    assign key_in   = KEY_BITS'(new_key);

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid & ~in_stall;
    // the output register can take a beat this cycle
    assign out_free = ~out_valid_reg | ~out_stall;

    // rotation steps only when the head cell's beat has a place to go
    assign ctl.rot  = (state_reg == S_ROT) & out_free;

    assign car_arr[0]     = inj_reg;
    assign car_key_arr[0] = inj_key_reg;

    genvar gi;
    generate
        for (gi = 0; gi < NODES; gi++)
        begin : g_cell
            slli_cell #(
                .KEY_BITS (KEY_BITS)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .cin      (car_arr[gi]),
                .cin_key  (car_key_arr[gi]),
                .rin_vld  (vld_arr[(gi + 1) % NODES]),
                .rin_key  (key_arr[(gi + 1) % NODES]),
                .vld      (vld_arr[gi]),
                .key      (key_arr[gi]),
                .cout     (car_arr[gi + 1]),
                .cout_key (car_key_arr[gi + 1]),
                .stat     (stat_arr[gi])
            );
            assign hit_vec[gi]  = stat_arr[gi].first_hit;
            assign land_vec[gi] = stat_arr[gi].landed;
        end
    endgenerate

    // the token sits at cell step_reg, so the cell where the new key settles gives its rank
    assign any_hit  = |hit_vec;
    assign any_land = |land_vec;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        count_next     = count_reg;
        inj_next       = '0;
        inj_key_next   = inj_key_reg;
        res_kind_next  = res_kind_reg;
        res_key_next   = res_key_reg;
        res_pos_next   = res_pos_reg;
        out_valid_next = out_valid_reg & out_stall;
        kind_next      = kind_reg;
        key_out_next   = key_out_reg;
        position_next  = position_reg;
        last_next      = last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    step_next = '0;
                    if (cmd == slli_pkg::CMD_READ)
                    begin
                        if (count_reg == '0)
                        begin
                            res_kind_next = slli_pkg::KIND_EMPTY;
                            res_key_next  = '0;
                            res_pos_next  = '0;
                            state_next    = S_RES;
                        end
                        else
                        begin
                            state_next = S_ROT;
                        end
                    end
                    else if (count_reg == CW'(NODES))
                    begin
                        // row full, nothing changes
                        res_kind_next = slli_pkg::KIND_OVERFLOW;
                        res_key_next  = 16'(key_in);
                        res_pos_next  = '0;
                        state_next    = S_RES;
                    end
                    else
                    begin
                        inj_next.valid = 1'b1;
                        inj_next.first = 1'b1;
                        inj_key_next   = key_in;
                        res_kind_next  = slli_pkg::KIND_INSERTED;
                        res_key_next   = 16'(key_in);
                        state_next     = S_INS;
                    end
                end
            end
            S_INS:
            begin
                step_next = step_reg + 1'b1;
                if (any_hit)
                begin
                    res_pos_next = 6'(step_reg);
                end
                if (any_land)
                begin
                    count_next = count_reg + 1'b1;
                    state_next = S_RES;
                end
            end
            S_ROT:
            begin
                if (out_free)
                begin
                    step_next = step_reg + 1'b1;
                    if (vld_arr[0])
                    begin
                        out_valid_next = 1'b1;
                        kind_next      = slli_pkg::KIND_ENTRY;
                        key_out_next   = 16'(key_arr[0]);
                        position_next  = 6'(step_reg);
                        last_next      = (step_reg == IW'(NODES - 1)) | ~vld_arr[1];
                    end
                    // a full turn puts every key back in its cell
                    if (step_reg == IW'(NODES - 1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_RES:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = res_kind_reg;
                    key_out_next   = res_key_reg;
                    position_next  = res_pos_reg;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            count_reg     <= '0;
            inj_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            count_reg     <= count_next;
            inj_reg       <= inj_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        inj_key_reg  <= inj_key_next;
        res_kind_reg <= res_kind_next;
        res_key_reg  <= res_key_next;
        res_pos_reg  <= res_pos_next;
        kind_reg     <= kind_next;
        key_out_reg  <= key_out_next;
        position_reg <= position_next;
        last_reg     <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign key_out   = key_out_reg;
    assign position  = position_reg;
    assign last      = last_reg;

    // an insert token always finds an empty cell before the end of the row
    a_no_spill: assert property (@(posedge clk) disable iff (!rst_n)
        !car_arr[NODES].valid)
        else $error("insert carry left the cell row");

    // at most one cell takes a token, and only during an insert
    a_land_once: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(land_vec) && (!any_land || state_reg == S_INS))
        else $error("bad landing of insert carry");

    // key count never exceeds the row
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(NODES))
        else $error("key count above row length");

    // an insert ends with its landing and raises the count by one
    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS && any_land) |=> (state_reg == S_RES
            && count_reg == $past(count_reg) + 1'b1))
        else $error("insert completion out of step with key count");

endmodule
